// ===== rtl/bcoal_pkg.sv =====
// Shared types and constants for the block request coalescer.
`timescale 1ns / 1ps
package bcoal_pkg;

   localparam int MAX_BUFFERS_DEF  = 32;
   localparam int SECTOR_BYTES_DEF = 512;
   localparam int STORE_LIMIT      = 32;

   typedef struct packed {
      logic [31:0] block_number;
      logic [15:0] buffer_bytes;
      logic [31:0] phys_address;
      logic        is_write;
      logic        last_in_batch;
   } req_type;

   typedef struct packed {
      logic        write_command;
      logic [4:0]  extent_index;
      logic [5:0]  extent_total;
      logic [38:0] start_sector;
      logic [11:0] sector_count;
      logic [31:0] segment_address;
      logic [20:0] segment_bytes;
      logic [4:0]  segment_index;
      logic        last_of_extent;
      logic        last_of_batch;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_ISSUE,
      ST_SORT_CMP,
      ST_SORT_STORE,
      ST_EXT_ISSUE,
      ST_EXT_EVAL,
      ST_EXT_FINAL,
      ST_EMIT_LEN,
      ST_EMIT_FIRST,
      ST_EMIT_DIV,
      ST_EMIT_MUL,
      ST_EMIT_ISSUE,
      ST_EMIT_CHECK,
      ST_EMIT_MID,
      ST_EMIT_LAST
   } state_type;

endpackage

// ===== rtl/bcoal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bcoal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/block_request_coalescer.sv =====
// Block request coalescer: sort a batch by block number, emit extents as SG segments.
//
//   channel | ports                          | direction
//   req     | req_valid, req_stall, req_data  | in  (one buffer descriptor)
//   rsp     | rsp_valid, rsp_stall, rsp_data  | out (one scatter-gather segment)
//
// Loading takes one buffer per cycle; req_stall is low only while loading.
// Sorting is a selection scan through one comparator, one pass per sorted slot.
// An extent pass then walks the sorted buffers; each extent is emitted by walking its
// buffers, merging address-contiguous ones into one segment.
// Reset clears control state only; buffer memories hold no reset value.
// A stalled rsp holds the output register and the sequencer waits on it.
`timescale 1ns / 1ps
module block_request_coalescer
   import bcoal_pkg::*;
#(
   parameter int MAX_BUFFERS  = MAX_BUFFERS_DEF,
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int STORE    = (MAX_BUFFERS < STORE_LIMIT) ? MAX_BUFFERS : STORE_LIMIT;
   localparam int AW       = $clog2(STORE);
   localparam int CW       = $clog2(STORE + 1);
   localparam int SPB_W    = $clog2(65535 / SECTOR_BYTES + 1);
   localparam int SB_SHIFT = $clog2(SECTOR_BYTES);

   state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    n_ff, n_in;
   logic             batch_write_ff, batch_write_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    e_ff, e_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    elen_ff, elen_in;
   logic [CW-1:0]    n_ext_ff, n_ext_in;
   logic             have_prev_ff, have_prev_in;
   logic             have_best_ff, have_best_in;
   logic [31:0]      prev_blk_ff, prev_blk_in;
   logic [CW-1:0]    prev_idx_ff, prev_idx_in;
   logic [31:0]      best_blk_ff, best_blk_in;
   logic [CW-1:0]    best_idx_ff, best_idx_in;
   logic [15:0]      best_size_ff, best_size_in;
   logic [31:0]      best_addr_ff, best_addr_in;
   logic [15:0]      rem_ff, rem_in;
   logic [SPB_W-1:0] spb_ff, spb_in;
   logic [38:0]      start_ff, start_in;
   logic [11:0]      scount_ff, scount_in;
   logic [31:0]      seg_addr_ff, seg_addr_in;
   logic [20:0]      seg_bytes_ff, seg_bytes_in;
   logic [4:0]       seg_ff, seg_in;
   logic [31:0]      pend_addr_ff, pend_addr_in;
   logic [15:0]      pend_size_ff, pend_size_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic          u_we;
   logic [31:0]   u_blk;
   logic [15:0]   u_size;
   logic [31:0]   u_addr;
   logic          s_we;
   logic [31:0]   s_blk;
   logic [15:0]   s_size;
   logic [31:0]   s_addr;
   logic          x_we;
   logic [CW-1:0] x_len;

   logic          req_take;
   logic [CW-1:0] n_m1;
   logic          i_last;
   logic          k_last;
   logic          gt_prev;
   logic          lt_best;
   logic          ext_new;
   logic          merge;
   logic          slot_free;
   logic [CW-1:0] j_next;
   logic          batch_end;

   bcoal_ram #(.WIDTH(32), .DEPTH(STORE)) u_blk_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_data.block_number), .rd_addr(i_ff[AW-1:0]), .rd_data(u_blk)
   );
   bcoal_ram #(.WIDTH(16), .DEPTH(STORE)) u_size_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_data.buffer_bytes), .rd_addr(i_ff[AW-1:0]), .rd_data(u_size)
   );
   bcoal_ram #(.WIDTH(32), .DEPTH(STORE)) u_addr_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_data.phys_address), .rd_addr(i_ff[AW-1:0]), .rd_data(u_addr)
   );
   bcoal_ram #(.WIDTH(32), .DEPTH(STORE)) s_blk_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(k_ff[AW-1:0]),
      .wr_data(best_blk_ff), .rd_addr(k_ff[AW-1:0]), .rd_data(s_blk)
   );
   bcoal_ram #(.WIDTH(16), .DEPTH(STORE)) s_size_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(k_ff[AW-1:0]),
      .wr_data(best_size_ff), .rd_addr(k_ff[AW-1:0]), .rd_data(s_size)
   );
   bcoal_ram #(.WIDTH(32), .DEPTH(STORE)) s_addr_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(k_ff[AW-1:0]),
      .wr_data(best_addr_ff), .rd_addr(k_ff[AW-1:0]), .rd_data(s_addr)
   );
   bcoal_ram #(.WIDTH(CW), .DEPTH(STORE)) x_len_ram (
      .clock(clock), .wr_en(x_we), .wr_addr(e_ff[AW-1:0]),
      .wr_data(len_ff), .rd_addr(e_ff[AW-1:0]), .rd_data(x_len)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign n_m1      = n_ff - CW'(1);
   assign i_last    = (i_ff == n_m1);
   assign k_last    = (k_ff == n_m1);
   assign gt_prev   = !have_prev_ff || (u_blk > prev_blk_ff) ||
                      ((u_blk == prev_blk_ff) && (i_ff > prev_idx_ff));
   assign lt_best   = !have_best_ff || (u_blk < best_blk_ff);
   assign ext_new   = (k_ff == '0) || ({1'b0, s_blk} != ({1'b0, prev_blk_ff} + 33'd1));
   assign merge     = (s_addr == (seg_addr_ff + 32'(seg_bytes_ff)));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign j_next    = j_ff + CW'(1);
   assign batch_end = (e_ff == (n_ext_ff - CW'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_data.last_in_batch) state_in = ST_SORT_ISSUE;
         end
         ST_SORT_ISSUE: state_in = ST_SORT_CMP;
         ST_SORT_CMP: begin
            state_in = i_last ? ST_SORT_STORE : ST_SORT_ISSUE;
         end
         ST_SORT_STORE: state_in = k_last ? ST_EXT_ISSUE : ST_SORT_ISSUE;
         ST_EXT_ISSUE: state_in = ST_EXT_EVAL;
         ST_EXT_EVAL: state_in = k_last ? ST_EXT_FINAL : ST_EXT_ISSUE;
         ST_EXT_FINAL: state_in = ST_EMIT_LEN;
         ST_EMIT_LEN: state_in = ST_EMIT_FIRST;
         ST_EMIT_FIRST: state_in = ST_EMIT_DIV;
         ST_EMIT_DIV: state_in = ST_EMIT_MUL;
         ST_EMIT_MUL: state_in = (elen_ff == CW'(1)) ? ST_EMIT_LAST : ST_EMIT_ISSUE;
         ST_EMIT_ISSUE: state_in = ST_EMIT_CHECK;
         ST_EMIT_CHECK: begin
            if (!merge) state_in = ST_EMIT_MID;
            else state_in = (j_next == elen_ff) ? ST_EMIT_LAST : ST_EMIT_ISSUE;
         end
         ST_EMIT_MID: begin
            if (slot_free) state_in = (j_next == elen_ff) ? ST_EMIT_LAST : ST_EMIT_ISSUE;
         end
         ST_EMIT_LAST: begin
            if (slot_free) state_in = batch_end ? ST_LOAD : ST_EMIT_LEN;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      n_in           = n_ff;
      batch_write_in = batch_write_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      e_in           = e_ff;
      len_in         = len_ff;
      j_in           = j_ff;
      elen_in        = elen_ff;
      n_ext_in       = n_ext_ff;
      have_prev_in   = have_prev_ff;
      have_best_in   = have_best_ff;
      prev_blk_in    = prev_blk_ff;
      prev_idx_in    = prev_idx_ff;
      best_blk_in    = best_blk_ff;
      best_idx_in    = best_idx_ff;
      best_size_in   = best_size_ff;
      best_addr_in   = best_addr_ff;
      rem_in         = rem_ff;
      spb_in         = spb_ff;
      start_in       = start_ff;
      scount_in      = scount_ff;
      seg_addr_in    = seg_addr_ff;
      seg_bytes_in   = seg_bytes_ff;
      seg_in         = seg_ff;
      pend_addr_in   = pend_addr_ff;
      pend_size_in   = pend_size_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      u_we           = 1'b0;
      s_we           = 1'b0;
      x_we           = 1'b0;

      rsp_data_in.write_command   = batch_write_ff;
      rsp_data_in.extent_index    = 5'(e_ff);
      rsp_data_in.extent_total    = 6'(n_ext_ff);
      rsp_data_in.start_sector    = start_ff;
      rsp_data_in.sector_count    = scount_ff;
      rsp_data_in.segment_address = seg_addr_ff;
      rsp_data_in.segment_bytes   = seg_bytes_ff;
      rsp_data_in.segment_index   = seg_ff;
      rsp_data_in.last_of_extent  = 1'b0;
      rsp_data_in.last_of_batch   = 1'b0;
      if (!slot_free) rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff == '0) batch_write_in = req_data.is_write;
               if (count_ff < CW'(STORE)) begin
                  u_we     = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last_in_batch) begin
                  n_in         = (count_ff < CW'(STORE)) ? count_ff + CW'(1) : count_ff;
                  count_in     = '0;
                  i_in         = '0;
                  k_in         = '0;
                  have_prev_in = 1'b0;
                  have_best_in = 1'b0;
               end
            end
         end
         ST_SORT_ISSUE: begin
         end
         ST_SORT_CMP: begin
            if (gt_prev && lt_best) begin
               have_best_in = 1'b1;
               best_blk_in  = u_blk;
               best_idx_in  = i_ff;
               best_size_in = u_size;
               best_addr_in = u_addr;
            end
            if (!i_last) i_in = i_ff + CW'(1);
         end
         ST_SORT_STORE: begin
            s_we         = 1'b1;
            have_prev_in = 1'b1;
            prev_blk_in  = best_blk_ff;
            prev_idx_in  = best_idx_ff;
            have_best_in = 1'b0;
            i_in         = '0;
            if (k_last) begin
               k_in   = '0;
               e_in   = '0;
               len_in = '0;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         ST_EXT_ISSUE: begin
         end
         ST_EXT_EVAL: begin
            prev_blk_in = s_blk;
            if (ext_new) begin
               len_in = CW'(1);
               if (k_ff != '0) begin
                  x_we = 1'b1;
                  e_in = e_ff + CW'(1);
               end
            end else begin
               len_in = len_ff + CW'(1);
            end
            if (!k_last) k_in = k_ff + CW'(1);
         end
         ST_EXT_FINAL: begin
            x_we     = 1'b1;
            n_ext_in = e_ff + CW'(1);
            e_in     = '0;
            k_in     = '0;
         end
         ST_EMIT_LEN: begin
         end
         ST_EMIT_FIRST: begin
            elen_in      = x_len;
            prev_blk_in  = s_blk;
            seg_addr_in  = s_addr;
            seg_bytes_in = 21'(s_size);
            rem_in       = s_size;
            spb_in       = '0;
            seg_in       = '0;
            j_in         = CW'(1);
         end
         ST_EMIT_DIV: begin
            spb_in = SPB_W'(rem_ff >> SB_SHIFT);
         end
         ST_EMIT_MUL: begin
            start_in  = 39'(prev_blk_ff) * 39'(spb_ff);
            scount_in = 12'(spb_ff) * 12'(elen_ff);
            k_in      = k_ff + CW'(1);
         end
         ST_EMIT_ISSUE: begin
         end
         ST_EMIT_CHECK: begin
            pend_addr_in = s_addr;
            pend_size_in = s_size;
            if (merge) begin
               seg_bytes_in = seg_bytes_ff + 21'(s_size);
               j_in         = j_next;
               k_in         = k_ff + CW'(1);
            end
         end
         ST_EMIT_MID: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               seg_in       = seg_ff + 5'd1;
               seg_addr_in  = pend_addr_ff;
               seg_bytes_in = 21'(pend_size_ff);
               j_in         = j_next;
               k_in         = k_ff + CW'(1);
            end
         end
         ST_EMIT_LAST: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.last_of_extent  = 1'b1;
               rsp_data_in.last_of_batch   = batch_end;
               e_in                        = e_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         batch_write_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         batch_write_ff <= batch_write_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      e_ff         <= e_in;
      len_ff       <= len_in;
      j_ff         <= j_in;
      elen_ff      <= elen_in;
      n_ext_ff     <= n_ext_in;
      have_prev_ff <= have_prev_in;
      have_best_ff <= have_best_in;
      prev_blk_ff  <= prev_blk_in;
      prev_idx_ff  <= prev_idx_in;
      best_blk_ff  <= best_blk_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
      best_addr_ff <= best_addr_in;
      rem_ff       <= rem_in;
      spb_ff       <= spb_in;
      start_ff     <= start_in;
      scount_ff    <= scount_in;
      seg_addr_ff  <= seg_addr_in;
      seg_bytes_ff <= seg_bytes_in;
      seg_ff       <= seg_in;
      pend_addr_ff <= pend_addr_in;
      pend_size_ff <= pend_size_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE))
      else $error("buffer count exceeds store depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) && rsp_valid_in |->
      (state_ff == ST_EMIT_MID || state_ff == ST_EMIT_LAST))
      else $error("transaction launched outside an emit state");

   a_batch_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LAST && slot_free && batch_end) |=> state_ff == ST_LOAD)
      else $error("sequencer missed end of batch");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_ISSUE) |-> (k_ff < n_ff))
      else $error("emit walk ran past the batch");

endmodule

// ===== bench/block_request_coalescer_tb.sv =====
// Testbench for the block request coalescer: predicts scatter-gather segments per batch.
`timescale 1ns / 1ps
module block_request_coalescer_tb;
   import bcoal_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int DEPTH          = (MAX_BUFFERS_DEF < STORE_LIMIT) ?
                                   MAX_BUFFERS_DEF : STORE_LIMIT;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type segment_q[$];
   int      err_count;
   int      hold_len;
   int      hold_left;
   bit      calm;
   int      quiet_cycles;

   logic [31:0] held_block[DEPTH];
   logic [15:0] held_bytes[DEPTH];
   logic [31:0] held_addr[DEPTH];
   int          held_count;
   bit          batch_dir;

   block_request_coalescer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Sort the held batch by block number, split into extents, merge contiguous buffers.
   task automatic coalesce_batch();
      int      order[DEPTH];
      int      first[DEPTH];
      int      len[DEPTH];
      int      n, n_ext, i, j, l, e, v, seg;
      longint  spb;
      bit [31:0] saddr;
      bit [31:0] sbytes;
      rsp_type r;
      n = held_count;
      for (i = 0; i < n; i++) begin
         v = i;
         j = i;
         while (j > 0 && held_block[order[j - 1]] > held_block[v]) begin
            order[j] = order[j - 1];
            j--;
         end
         order[j] = v;
      end
      n_ext = 0;
      i = 0;
      while (i < n) begin
         l = i + 1;
         while (l < n && longint'(held_block[order[l]]) ==
                longint'(held_block[order[i]]) + longint'(l - i))
            l++;
         first[n_ext] = i;
         len[n_ext] = l - i;
         n_ext++;
         i = l;
      end
      for (e = 0; e < n_ext; e++) begin
         spb = longint'(held_bytes[order[first[e]]]) / 512;
         r = '0;
         r.write_command = batch_dir;
         r.extent_index  = e[4:0];
         r.extent_total  = n_ext[5:0];
         r.start_sector  = 39'(longint'(held_block[order[first[e]]]) * spb);
         r.sector_count  = 12'(spb * len[e]);
         saddr  = held_addr[order[first[e]]];
         sbytes = 32'(held_bytes[order[first[e]]]);
         seg = 0;
         for (i = first[e] + 1; i < first[e] + len[e]; i++) begin
            if (held_addr[order[i]] == saddr + sbytes) begin
               sbytes += 32'(held_bytes[order[i]]);
            end else begin
               r.segment_address = saddr;
               r.segment_bytes   = sbytes[20:0];
               r.segment_index   = seg[4:0];
               r.last_of_extent  = 1'b0;
               segment_q.push_back(r);
               seg++;
               saddr  = held_addr[order[i]];
               sbytes = 32'(held_bytes[order[i]]);
            end
         end
         r.segment_address = saddr;
         r.segment_bytes   = sbytes[20:0];
         r.segment_index   = seg[4:0];
         r.last_of_extent  = 1'b1;
         segment_q.push_back(r);
      end
      segment_q[segment_q.size() - 1].last_of_batch = 1'b1;
      held_count = 0;
   endtask

   task automatic record_desc(input req_type d);
      if (held_count == 0)
         batch_dir = d.is_write;
      if (held_count < DEPTH) begin
         held_block[held_count] = d.block_number;
         held_bytes[held_count] = d.buffer_bytes;
         held_addr[held_count]  = d.phys_address;
         held_count++;
      end
      if (d.last_in_batch)
         coalesce_batch();
   endtask

   task automatic send_desc(input logic [31:0] blk, input logic [15:0] bytes,
                            input logic [31:0] addr, input bit wr, input bit last);
      req_type d;
      d.block_number  = blk;
      d.buffer_bytes  = bytes;
      d.phys_address  = addr;
      d.is_write      = wr;
      d.last_in_batch = last;
      if (!calm && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do
         @(posedge clock);
      while (req_stall);
      record_desc(d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segment_q.size() != 0)
         @(posedge clock);
   endtask

   // Build one batch of consecutive runs with mostly contiguous addresses, then shuffle it.
   task automatic send_random_batch(input int n);
      logic [31:0] blk[DEPTH + 4];
      logic [15:0] bytes[DEPTH + 4];
      logic [31:0] addr[DEPTH + 4];
      logic [31:0] b, a;
      logic [15:0] s;
      int i, k;
      bit wild, wr;
      wild = ($urandom_range(0, 3) == 0);
      wr = 1'($urandom_range(0, 1));
      b = $urandom();
      a = $urandom();
      s = 16'($urandom_range(1, 8) * 512);
      for (i = 0; i < n; i++) begin
         if (i > 0) begin
            k = $urandom_range(0, 9);
            if (k == 0)
               b = $urandom();
            else if (k == 1)
               b = b;
            else
               b = b + 1;
            if ($urandom_range(0, 3) == 0)
               a = $urandom();
            else
               a = a + 32'(s);
            if (wild)
               s = 16'($urandom());
         end
         blk[i] = b;
         bytes[i] = s;
         addr[i] = a;
      end
      for (i = n - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         {blk[i], blk[k]} = {blk[k], blk[i]};
         {bytes[i], bytes[k]} = {bytes[k], bytes[i]};
         {addr[i], addr[k]} = {addr[k], addr[i]};
      end
      for (i = 0; i < n; i++)
         send_desc(blk[i], bytes[i], addr[i], (i == 0) ? wr : bit'($urandom_range(0, 1)),
                   i == n - 1);
   endtask

   task automatic test_directed();
      send_desc(32'h0, 16'd512, 32'h0, 1'b0, 1'b1);
      send_desc(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_desc(32'd10, 16'd511, 32'h1000, 1'b0, 1'b0);
      send_desc(32'd11, 16'd0, 32'h2000, 1'b0, 1'b0);
      send_desc(32'd20, 16'd0, 32'h3000, 1'b0, 1'b1);
      send_desc(32'd7, 16'd1024, 32'h8000, 1'b1, 1'b0);
      send_desc(32'd3, 16'd1024, 32'h4400, 1'b0, 1'b0);
      send_desc(32'd7, 16'd1024, 32'h9000, 1'b0, 1'b0);
      send_desc(32'd4, 16'd1024, 32'h4800, 1'b1, 1'b0);
      send_desc(32'd2, 16'd1024, 32'h4000, 1'b0, 1'b1);
      send_desc(32'd100, 16'd512, 32'hFFFF_FE00, 1'b0, 1'b0);
      send_desc(32'd101, 16'd512, 32'h0, 1'b1, 1'b1);
      send_desc(32'hFFFF_FFFF, 16'd2048, 32'h100, 1'b1, 1'b0);
      send_desc(32'h0, 16'd2048, 32'h900, 1'b0, 1'b1);
      send_desc(32'd50, 16'd4096, 32'hA000, 1'b1, 1'b0);
      send_desc(32'd51, 16'd512, 32'hB000, 1'b0, 1'b0);
      send_desc(32'd52, 16'd512, 32'hB200, 1'b0, 1'b1);
      drain();
   endtask

   task automatic test_full_store();
      int i;
      for (i = 0; i < DEPTH + 3; i++)
         send_desc(32'(1000 + i), 16'd512, 32'(32'h20000 + 512 * i), 1'b1,
                   i == DEPTH + 2);
      drain();
   endtask

   task automatic test_backpressure();
      hold_len = 400;
      send_random_batch(12);
      send_random_batch(4);
      drain();
   endtask

   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 20) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH) : $urandom_range(1, 6);
         send_random_batch(n);
         sent += n;
         if ($urandom_range(0, 7) == 0)
            drain();
      end
      drain();
   endtask

   task automatic test_no_idle();
      int i;
      calm = 1'b1;
      for (i = 0; i < 4; i++)
         send_random_batch($urandom_range(1, 6));
      drain();
      calm = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (segment_q.size() == 0) begin
               $display("%0t unexpected transaction %p", $time, rsp_data);
               err_count++;
            end else begin
               want = segment_q.pop_front();
               check_field("write_command", 64'(want.write_command),
                           64'(rsp_data.write_command));
               check_field("extent_index", 64'(want.extent_index),
                           64'(rsp_data.extent_index));
               check_field("extent_total", 64'(want.extent_total),
                           64'(rsp_data.extent_total));
               check_field("start_sector", 64'(want.start_sector),
                           64'(rsp_data.start_sector));
               check_field("sector_count", 64'(want.sector_count),
                           64'(rsp_data.sector_count));
               check_field("segment_address", 64'(want.segment_address),
                           64'(rsp_data.segment_address));
               check_field("segment_bytes", 64'(want.segment_bytes),
                           64'(rsp_data.segment_bytes));
               check_field("segment_index", 64'(want.segment_index),
                           64'(rsp_data.segment_index));
               check_field("last_of_extent", 64'(want.last_of_extent),
                           64'(rsp_data.last_of_extent));
               check_field("last_of_batch", 64'(want.last_of_batch),
                           64'(rsp_data.last_of_batch));
            end
         end
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 37);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[block_request_coalescer] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      err_count = 0;
      hold_len = 0;
      calm = 1'b0;
      quiet_cycles = 0;
      held_count = 0;
      batch_dir = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_backpressure();
      test_no_idle();
      test_random();
      repeat (200) @(posedge clock);
      if (err_count == 0 && segment_q.size() == 0)
         $display("[block_request_coalescer] OK");
      else
         $display("[block_request_coalescer] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bcoal_pkg.sv
rtl/bcoal_ram.sv
rtl/block_request_coalescer.sv
bench/block_request_coalescer_tb.sv
